// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/kgt_pkg.sv =====
// ---------------------------------------------------------------------------
// kgt_pkg
// Shared types and constants of the keyed grant table.
// ---------------------------------------------------------------------------
`default_nettype none
package kgt_pkg;
	localparam int unsigned CAPACITY_DEF   = 16;
	localparam int unsigned UNIT_KINDS_DEF = 4;

	typedef enum logic [1:0] {
		ACT_PUT    = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_FIND   = 2'd2,
		ACT_PURGE  = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_DONE     = 3'd0,
		ST_INVALID  = 3'd1,
		ST_RANGE    = 3'd2,
		ST_REGRESS  = 3'd3,
		ST_FULL     = 3'd4,
		ST_NOTFOUND = 3'd5
	} status_t;

	// one stored grant record (key held separately)
	typedef struct packed {
		logic [31:0] grant_id;
		logic [31:0] generation;
		logic [31:0] epoch;
		logic [7:0]  unit;
		logic [31:0] floor_v;
		logic [31:0] ceiling_v;
		logic [63:0] granted_tick;
		logic [63:0] expiry_tick;
	} record_t;

	localparam int unsigned REC_W = $bits(record_t);

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture request
		logic scan_clr;  // reset scan state
		logic scan_en;   // examine current slot read data
		logic write;     // write record into chosen slot
		logic clr_used;  // clear used bit of chosen slot
		logic purge_drop;// drop current scanned slot if stale
		logic out_load;  // load result register
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic invalid;
		logic bad_range;
		logic found;
		logic has_free;
		logic regress;
		logic scan_last;
	} dp_sts_t;
endpackage
`default_nettype wire

// ===== src/kgt_ram.sv =====
// ---------------------------------------------------------------------------
// kgt_ram
// Generic single-port-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none
module kgt_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire                       clk,
	input  wire                       we,
	input  wire [$clog2(DEPTH)-1:0]   waddr,
	input  wire [WIDTH-1:0]           wdata,
	input  wire [$clog2(DEPTH)-1:0]   raddr,
	output logic [WIDTH-1:0]          rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== src/kgt_ctrl.sv =====
// ---------------------------------------------------------------------------
// kgt_ctrl
// Sequencer: capture, check, scan the table, then commit and present.
// ---------------------------------------------------------------------------
`default_nettype none
module kgt_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire                out_ready,
	input  wire kgt_pkg::action_t act,
	input  wire kgt_pkg::dp_sts_t sts,
	output kgt_pkg::dp_cmd_t   cmd
);
	import kgt_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_PRIME = 5'b00010,
		S_SCAN  = 5'b00100,
		S_DONE  = 5'b01000,
		S_OUT   = 5'b10000
	} state_t;

	state_t state_q, state_nx;

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nx = S_PRIME;
				end
			end
			S_PRIME: begin
				// first read address issued; read data arrives next cycle
				cmd.scan_clr = 1'b1;
				state_nx = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan_en = 1'b1;
				if (act == ACT_PURGE) begin
					cmd.purge_drop = 1'b1;
				end
				if (sts.scan_last) begin
					state_nx = S_DONE;
				end
			end
			S_DONE: begin
				cmd.out_load = 1'b1;
				case (act)
					ACT_PUT: begin
						if (!sts.invalid && !sts.bad_range &&
							((sts.found && !sts.regress) ||
							(!sts.found && sts.has_free))) begin
							cmd.write = 1'b1;
						end
					end
					ACT_REMOVE: cmd.clr_used = sts.found;
					default: ;
				endcase
				state_nx = S_OUT;
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end
endmodule
`default_nettype wire

// ===== src/kgt_dp.sv =====
// ---------------------------------------------------------------------------
// kgt_dp
// Request register, slot stores, scan counter and result register.
// ---------------------------------------------------------------------------
`default_nettype none
module kgt_dp #(
	parameter int unsigned CAPACITY   = kgt_pkg::CAPACITY_DEF,
	parameter int unsigned UNIT_KINDS = kgt_pkg::UNIT_KINDS_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire kgt_pkg::dp_cmd_t cmd,
	output kgt_pkg::dp_sts_t     sts,
	output kgt_pkg::action_t     act,
	input  wire [1:0]            action,
	input  wire [31:0]           resource_key,
	input  wire [31:0]           grant_id,
	input  wire [31:0]           generation_in,
	input  wire [31:0]           epoch_in,
	input  wire [7:0]            unit_in,
	input  wire [31:0]           floor_in,
	input  wire [31:0]           ceiling_in,
	input  wire [63:0]           granted_tick_in,
	input  wire [63:0]           expiry_tick_in,
	input  wire [63:0]           current_tick,
	output logic [2:0]           status,
	output logic                 hit,
	output logic [31:0]          grant_id_out,
	output logic [31:0]          generation_out,
	output logic [31:0]          epoch_out,
	output logic [7:0]           unit_out,
	output logic [31:0]          floor_out,
	output logic [31:0]          ceiling_out,
	output logic [63:0]          granted_tick_out,
	output logic [63:0]          expiry_tick_out,
	output logic [4:0]           dropped_count
);
	import kgt_pkg::*;

	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CW = $clog2(CAPACITY + 1);

	// request
	action_t     act_q;
	logic [31:0] key_q;
	record_t     req_q;
	logic [63:0] now_q;

	// scan state
	logic [AW-1:0] raddr_q;     // address issued to RAM
	logic [AW-1:0] cur_q;       // slot whose data is on rdata
	logic          found_q;
	logic [AW-1:0] found_idx_q;
	logic          free_q;
	logic [AW-1:0] free_idx_q;
	logic [CW-1:0] drop_q;
	logic [CAPACITY-1:0] used_q;

	logic [31:0] key_rd;
	record_t     rec_rd;
	record_t     found_rec_q;

	logic          we;
	logic [AW-1:0] waddr;
	logic          cur_match;
	logic          stale;
	logic [8:0]    unit_ext;

	assign act = act_q;
	assign unit_ext = {1'b0, req_q.unit};

	assign we    = cmd.write;
	assign waddr = found_q ? found_idx_q : free_idx_q;

	kgt_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_key_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(key_q),
		.raddr(raddr_q), .rdata(key_rd)
	);
	kgt_ram #(.WIDTH(REC_W), .DEPTH(CAPACITY)) u_rec_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(req_q),
		.raddr(raddr_q), .rdata(rec_rd)
	);

	assign cur_match = used_q[cur_q] && (key_rd == key_q);
	assign stale = used_q[cur_q] &&
		((rec_rd.epoch != req_q.epoch) || (rec_rd.expiry_tick <= now_q));

	assign sts.invalid = (key_q == '0) || (req_q.grant_id == '0) ||
		(req_q.generation == '0) || (unit_ext >= 9'(UNIT_KINDS));
	assign sts.bad_range = (req_q.ceiling_v < req_q.floor_v) ||
		(req_q.expiry_tick < req_q.granted_tick);
	assign sts.found = found_q;
	assign sts.has_free = free_q;
	assign sts.regress = (req_q.generation <= found_rec_q.generation) &&
		(req_q.epoch <= found_rec_q.epoch);
	assign sts.scan_last = (cur_q == AW'(CAPACITY - 1));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q  <= action_t'(action);
			key_q  <= resource_key;
			req_q  <= '{grant_id, generation_in, epoch_in, unit_in, floor_in,
				ceiling_in, granted_tick_in, expiry_tick_in};
			now_q  <= current_tick;
		end
		if (cmd.scan_en && cur_match && !found_q) begin
			found_idx_q <= cur_q;
			found_rec_q <= rec_rd;
		end
		if (cmd.scan_en && !used_q[cur_q] && !free_q) begin
			free_idx_q <= cur_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= '0;
			raddr_q <= '0;
			cur_q   <= '0;
			found_q <= 1'b0;
			free_q  <= 1'b0;
			drop_q  <= '0;
		end else begin
			if (cmd.load) begin
				raddr_q <= '0;
			end else if (cmd.scan_clr || cmd.scan_en) begin
				// advance read address, hold at last slot
				if (raddr_q != AW'(CAPACITY - 1)) begin
					raddr_q <= raddr_q + 1'b1;
				end
			end
			if (cmd.scan_clr) begin
				cur_q   <= '0;
				found_q <= 1'b0;
				free_q  <= 1'b0;
				drop_q  <= '0;
			end else if (cmd.scan_en) begin
				if (!sts.scan_last) begin
					cur_q <= cur_q + 1'b1;
				end
				if (cur_match) begin
					found_q <= 1'b1;
				end
				if (!used_q[cur_q]) begin
					free_q <= 1'b1;
				end
				if (cmd.purge_drop && stale) begin
					used_q[cur_q] <= 1'b0;
					drop_q <= drop_q + 1'b1;
				end
			end
			if (cmd.write) begin
				used_q[waddr] <= 1'b1;
			end
			if (cmd.clr_used) begin
				used_q[found_idx_q] <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			status <= ST_DONE;
			hit <= 1'b0;
			grant_id_out <= '0;
			generation_out <= '0;
			epoch_out <= '0;
			unit_out <= '0;
			floor_out <= '0;
			ceiling_out <= '0;
			granted_tick_out <= '0;
			expiry_tick_out <= '0;
			dropped_count <= '0;
			case (act_q)
				ACT_PUT: begin
					if (sts.invalid) status <= ST_INVALID;
					else if (sts.bad_range) status <= ST_RANGE;
					else if (found_q && sts.regress) status <= ST_REGRESS;
					else if (!found_q && !free_q) status <= ST_FULL;
				end
				ACT_REMOVE, ACT_FIND: begin
					if (!found_q) begin
						status <= ST_NOTFOUND;
					end else begin
						hit <= 1'b1;
						if (act_q == ACT_FIND) begin
							grant_id_out     <= found_rec_q.grant_id;
							generation_out   <= found_rec_q.generation;
							epoch_out        <= found_rec_q.epoch;
							unit_out         <= found_rec_q.unit;
							floor_out        <= found_rec_q.floor_v;
							ceiling_out      <= found_rec_q.ceiling_v;
							granted_tick_out <= found_rec_q.granted_tick;
							expiry_tick_out  <= found_rec_q.expiry_tick;
						end
					end
				end
				ACT_PURGE: dropped_count <= 5'(drop_q);
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== src/keyed_grant_table_unit.sv =====
// Flow: the input beat is captured, one read is primed, every slot is then
// scanned one slot per cycle through the registered read port, the result is
// committed and the result beat is held until out_ready. A new input is
// accepted only once the previous result beat completes.
// Reset: arst_n clears the controller and every slot's used bit at once,
// so the table is empty immediately; slot RAM contents are not cleared.
// ---------------------------------------------------------------------------
// keyed_grant_table_unit
// Fixed-capacity grant table keyed by resource id: put, remove, find, purge.
// ---------------------------------------------------------------------------
`default_nettype none
module keyed_grant_table_unit #(
	parameter int unsigned CAPACITY   = kgt_pkg::CAPACITY_DEF,
	parameter int unsigned UNIT_KINDS = kgt_pkg::UNIT_KINDS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire [1:0]   action,
	input  wire [31:0]  resource_key,
	input  wire [31:0]  grant_id,
	input  wire [31:0]  generation_in,
	input  wire [31:0]  epoch_in,
	input  wire [7:0]   unit_in,
	input  wire [31:0]  floor_in,
	input  wire [31:0]  ceiling_in,
	input  wire [63:0]  granted_tick_in,
	input  wire [63:0]  expiry_tick_in,
	input  wire [63:0]  current_tick,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [2:0]  status,
	output logic        hit,
	output logic [31:0] grant_id_out,
	output logic [31:0] generation_out,
	output logic [31:0] epoch_out,
	output logic [7:0]  unit_out,
	output logic [31:0] floor_out,
	output logic [31:0] ceiling_out,
	output logic [63:0] granted_tick_out,
	output logic [63:0] expiry_tick_out,
	output logic [4:0]  dropped_count
);
	import kgt_pkg::*;

	// command and status between sequencer and datapath
	dp_cmd_t cmd;
	dp_sts_t sts;
	action_t act;

	// sequencer: idle -> prime read -> scan all slots -> commit -> hold beat
	kgt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.act(act), .sts(sts), .cmd(cmd)
	);

	// datapath: request capture, slot RAMs, scan results, result register
	kgt_dp #(.CAPACITY(CAPACITY), .UNIT_KINDS(UNIT_KINDS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .act(act),
		.action(action), .resource_key(resource_key), .grant_id(grant_id),
		.generation_in(generation_in), .epoch_in(epoch_in), .unit_in(unit_in),
		.floor_in(floor_in), .ceiling_in(ceiling_in),
		.granted_tick_in(granted_tick_in), .expiry_tick_in(expiry_tick_in),
		.current_tick(current_tick),
		.status(status), .hit(hit), .grant_id_out(grant_id_out),
		.generation_out(generation_out), .epoch_out(epoch_out),
		.unit_out(unit_out), .floor_out(floor_out), .ceiling_out(ceiling_out),
		.granted_tick_out(granted_tick_out), .expiry_tick_out(expiry_tick_out),
		.dropped_count(dropped_count)
	);
endmodule
`default_nettype wire

// ===== src/kgt_checker.sv =====
// ---------------------------------------------------------------------------
// kgt_checker
// Port-level checks of the grant table, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module kgt_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_ready,
	input wire        out_valid,
	input wire        out_ready,
	input wire [2:0]  status,
	input wire        hit,
	input wire [4:0]  dropped_count
);
	import kgt_pkg::*;

	`CHK_IMPLY(a_one_side, clk, arst_n, out_valid, !in_ready, "ready while result pending")
	`CHK_IMPLY(a_hit_done, clk, arst_n, out_valid && hit, status == ST_DONE, "hit without done")
	`CHK_IMPLY(a_status_rng, clk, arst_n, out_valid, status <= ST_NOTFOUND, "status out of range")
	`CHK_NEXT(a_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(status) && $stable(dropped_count), "result changed")
	`CHK_NEXT(a_accept, clk, arst_n, in_valid && in_ready, !in_ready && !out_valid,
		"beat overlap")
endmodule

bind keyed_grant_table_unit kgt_checker u_kgt_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .status(status), .hit(hit),
	.dropped_count(dropped_count)
);
`default_nettype wire
